FILE: hdl/lhmu_pkg.sv
package lhmu_pkg;

	localparam int MODULUS     = 12289;
	localparam int LOG2_BUCKET = 9;
	localparam int BUCKETS     = 48;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;

	localparam logic [14:0] TWO_Q     = 15'(2 * MODULUS);
	localparam logic [15:0] Q_VAL     = 16'(MODULUS);
	localparam logic [15:0] HALF_Q    = 16'((MODULUS - 1) / 2);
	localparam logic [15:0] ALPHA_RND = 16'((1 << LOG2_BUCKET) / 2);
	localparam logic [6:0]  NBUCKET   = 7'(BUCKETS);

	typedef enum logic {
		OP_MAKE = 1'b0,
		OP_USE  = 1'b1
	} op_t;

	typedef struct packed {
		logic        first_row;
		logic        lsb_bit;
		logic [5:0]  hint_in;
		logic [13:0] response_coeff;
		logic [14:0] commit_value;
	} req_t;

	typedef struct packed {
		logic [13:0] recovered_response;
		logic [5:0]  recovered_high;
		logic [5:0]  hint_out;
	} res_t;

	function automatic logic [5:0] high_bucket(input logic [14:0] x);
		logic [15:0] s;
		logic [6:0]  b;
		s = {1'b0, x} + ALPHA_RND;
		b = 7'(s >> LOG2_BUCKET);
		if (b >= NBUCKET)
			b = b - NBUCKET;
		return b[5:0];
	endfunction

endpackage

FILE: hdl/lhmu_calc.sv
module lhmu_calc (
	input  lhmu_pkg::op_t  op,
	input  lhmu_pkg::req_t req,
	output lhmu_pkg::res_t res
);
	import lhmu_pkg::*;

	logic [14:0]        cv;
	logic signed [16:0] t;
	logic [14:0]        wt;
	logic [5:0]         hb_cv;
	logic [5:0]         hb_wt;
	logic [6:0]         d;
	logic [6:0]         sum;
	logic [5:0]         ch;
	logic [14:0]        app;
	logic signed [16:0] e;
	logic signed [15:0] h;
	logic signed [15:0] r;

	always_comb begin
		cv = (req.commit_value >= TWO_Q) ? req.commit_value - TWO_Q : req.commit_value;

		// wt = (w - 2*z2) mod 2q, one correction either way suffices
		t = $signed({2'b00, cv}) -
			$signed({{2{req.response_coeff[13]}}, req.response_coeff, 1'b0});
		if (t < 0)
			t = t + $signed({2'b00, TWO_Q});
		else if (t >= $signed({2'b00, TWO_Q}))
			t = t - $signed({2'b00, TWO_Q});
		wt = t[14:0];

		hb_cv = high_bucket(cv);
		hb_wt = high_bucket(wt);

		d = {1'b0, hb_cv} - {1'b0, hb_wt};
		if (d[6])
			d = d + NBUCKET;

		sum = {1'b0, req.hint_in} + {1'b0, hb_cv};
		if (sum >= 7'(2 * BUCKETS))
			sum = sum - 7'(2 * BUCKETS);
		else if (sum >= NBUCKET)
			sum = sum - NBUCKET;
		ch = sum[5:0];

		app = 15'({ch, LOG2_BUCKET'(0)}) | 15'(req.first_row & req.lsb_bit);
		e = $signed({2'b00, app}) - $signed({2'b00, cv});
		h = e[16:1];
		r = h;
		if (r < 0)
			r = r + $signed(Q_VAL);
		if (r > $signed(HALF_Q))
			r = r - $signed(Q_VAL);

		res = '0;
		case (op)
			OP_MAKE: res.hint_out = d[5:0];
			OP_USE: begin
				res.recovered_high     = ch;
				res.recovered_response = r[13:0];
			end
			default: res = '0;
		endcase
	end

endmodule

FILE: hdl/lattice_hint_make_use_core.sv
// Pipeline: input register, then result register; the hint logic is a single pass
// between the two. Throughput: one request per cycle unless m_tready is held low.
// The result register lets a new request enter while a result waits on m_tready.
// Reset: arst_n asynchronous, active low, clears both valid flags; data is not reset.
module lattice_hint_make_use_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// commit_value[14:0], response_coeff[28:15], hint_in[34:29], lsb_bit[35],
	// first_row[36], zero[39:37]
	input  logic [lhmu_pkg::IN_DATA_W-1:0]       s_tdata,
	// opcode[0]
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// hint_out[5:0], recovered_high[11:6], recovered_response[25:12], zero[31:26]
	output logic [lhmu_pkg::OUT_DATA_W-1:0]      m_tdata
);
	import lhmu_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	req_t req_s1;
	res_t res_comb;
	res_t res_q;
	logic out_valid_q;
	logic advance;
	logic s_acc;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1  <= op_t'(s_tuser);
			req_s1 <= req_t'(s_tdata[$bits(req_t)-1:0]);
		end
	end

	lhmu_calc u_calc (
		.op  (op_s1),
		.req (req_s1),
		.res (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_comb;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), res_q};

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> valid_s1)
		else $error("accepted request lost at stage 1");

	a_move_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> m_tvalid)
		else $error("stage 1 request not moved to result register");

	a_mode_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:0] != 6'd0) |-> (m_tdata[25:6] == 20'd0))
		else $error("make and use fields both nonzero");

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] < 6'(BUCKETS)) && (m_tdata[11:6] < 6'(BUCKETS)))
		else $error("bucket out of range");
`endif

endmodule
